// ===== rtl/esc_pkg.sv =====
`timescale 1ns / 1ps

package esc_pkg;

    localparam int MEANS = 4;
    localparam int AVG_DIV = MEANS * 26;
    localparam int MUL_STEPS = 32;
    localparam int DIV_STEPS = 64;

    localparam logic [2:0] CFG_TEMP = 3'd0;
    localparam logic [2:0] CFG_PRESS_LO = 3'd1;
    localparam logic [2:0] CFG_PRESS_HI = 3'd2;
    localparam logic [2:0] CFG_PRESS_P9 = 3'd3;
    localparam logic [2:0] CFG_HUM_A = 3'd4;
    localparam logic [2:0] CFG_HUM_B = 3'd5;

    typedef struct packed {
        logic [19:0] raw_temp;
        logic [19:0] raw_press;
        logic [15:0] raw_hum;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] temp_centi;
        logic [20:0] press_deci_pa;
        logic [6:0] hum_percent;
        logic press_zero_div;
    } t_out_word;

    function automatic logic [63:0] sra64(input logic [63:0] x, input int unsigned s);
        return 64'($signed(x) >>> s);
    endfunction

    function automatic logic [63:0] sx32(input logic [63:0] x);
        return {{32{x[31]}}, x[31:0]};
    endfunction

endpackage

// ===== rtl/esc_in_if.sv =====
`timescale 1ns / 1ps

interface esc_in_if;
    logic valid;
    logic ready;
    esc_pkg::t_in_word data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/esc_out_if.sv =====
`timescale 1ns / 1ps

interface esc_out_if;
    logic valid;
    logic ready;
    esc_pkg::t_out_word data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/esc_mul.sv =====
`timescale 1ns / 1ps

module esc_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_prod,
    output logic        o_done
);
    import esc_pkg::*;

    localparam int CW = $clog2(MUL_STEPS);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [63:0]   r_a;
    logic [63:0]   r_b;
    logic [63:0]   r_acc;
    logic [63:0]   w_pp0;
    logic [63:0]   w_pp1;

    assign w_pp0 = r_b[0] ? r_a : 64'd0;
    assign w_pp1 = r_b[1] ? {r_a[62:0], 1'b0} : 64'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + w_pp0 + w_pp1;
            r_a   <= {r_a[61:0], 2'b00};
            r_b   <= {2'b00, r_b[63:2]};
        end
    end

    assign o_prod = r_acc;
    assign o_done = r_done;

endmodule

// ===== rtl/esc_div.sv =====
`timescale 1ns / 1ps

module esc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic [63:0] o_quo,
    output logic        o_done
);
    import esc_pkg::*;

    localparam int CW = $clog2(DIV_STEPS);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [63:0]   r_rem;
    logic [63:0]   r_quo;
    logic [63:0]   r_den;
    logic [64:0]   w_sh;
    logic [64:0]   w_diff;

    assign w_sh   = {r_rem, r_quo[63]};
    assign w_diff = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_diff[64]) begin
                r_rem <= w_diff[63:0];
                r_quo <= {r_quo[62:0], 1'b1};
            end else begin
                r_rem <= w_sh[63:0];
                r_quo <= {r_quo[62:0], 1'b0};
            end
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

// ===== rtl/env_sensor_compensation_core.sv =====
`timescale 1ns / 1ps
// Environmental sensor compensation core.
// Input words carry raw temperature, pressure and humidity readings; items form
// groups of MEANS. The first item of a group computes temperature and humidity,
// every item adds one compensated pressure until a zero divisor is met in the
// group, and the last item produces one output word with the averaged pressure.
// Calibration coefficients must be loaded through the write port while idle; the core
// does not enforce this. One shared shift-add multiplier (two bits per cycle) and one
// restoring divider (one bit per cycle) do all the work. A first item of a group runs
// the temperature, humidity and pressure steps, later items run only the pressure
// steps, and the last item adds the averaging division.
// A new word is taken only when the previous item is finished. The result sits
// in an output register; the core keeps accepting input while it waits, and
// only stalls at the end of the next group if that word has not been taken.
// Reset clears the coefficients, the group state and the output valid.
module env_sensor_compensation_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    esc_in_if.sink      i_in,
    esc_out_if.source   o_out
);
    import esc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;

    localparam logic [4:0] ST_T0  = 5'd0;
    localparam logic [4:0] ST_T1  = 5'd1;
    localparam logic [4:0] ST_T2  = 5'd2;
    localparam logic [4:0] ST_T3  = 5'd3;
    localparam logic [4:0] ST_T4  = 5'd4;
    localparam logic [4:0] ST_H0  = 5'd5;
    localparam logic [4:0] ST_H1  = 5'd6;
    localparam logic [4:0] ST_H2  = 5'd7;
    localparam logic [4:0] ST_H3  = 5'd8;
    localparam logic [4:0] ST_H4  = 5'd9;
    localparam logic [4:0] ST_H5  = 5'd10;
    localparam logic [4:0] ST_H6  = 5'd11;
    localparam logic [4:0] ST_H7  = 5'd12;
    localparam logic [4:0] ST_H8  = 5'd13;
    localparam logic [4:0] ST_H9  = 5'd14;
    localparam logic [4:0] ST_P0  = 5'd15;
    localparam logic [4:0] ST_P1  = 5'd16;
    localparam logic [4:0] ST_P2  = 5'd17;
    localparam logic [4:0] ST_P3  = 5'd18;
    localparam logic [4:0] ST_P4  = 5'd19;
    localparam logic [4:0] ST_P5  = 5'd20;
    localparam logic [4:0] ST_P6  = 5'd21;
    localparam logic [4:0] ST_P7  = 5'd22;
    localparam logic [4:0] ST_P8  = 5'd23;
    localparam logic [4:0] ST_P9  = 5'd24;
    localparam logic [4:0] ST_P10 = 5'd25;
    localparam logic [4:0] ST_P11 = 5'd26;
    localparam logic [4:0] ST_P12 = 5'd27;
    localparam logic [4:0] ST_P13 = 5'd28;
    localparam logic [4:0] ST_P14 = 5'd29;
    localparam logic [4:0] ST_END = 5'd30;
    localparam logic [4:0] ST_AVG = 5'd31;

    logic [47:0] r_c_temp;
    logic [63:0] r_c_plo;
    logic [63:0] r_c_phi;
    logic [15:0] r_c_p9;
    logic [39:0] r_c_ha;
    logic [31:0] r_c_hb;

    logic [1:0]  r_state, n_state;
    logic [4:0]  r_step, n_step;
    t_in_word    r_in, n_in;
    logic [63:0] r_ra, n_ra;
    logic [63:0] r_rb, n_rb;
    logic [63:0] r_rc, n_rc;
    logic [63:0] r_rd, n_rd;
    logic        r_neg, n_neg;
    logic [31:0] r_fine, n_fine;
    logic [39:0] r_sum, n_sum;
    logic [7:0]  r_cnt, n_cnt;
    logic        r_zflag, n_zflag;
    logic [15:0] r_temp, n_temp;
    logic [6:0]  r_hum, n_hum;
    t_out_word   r_out, n_out;
    logic        r_ovalid, n_ovalid;

    logic        w_mul_start;
    logic [63:0] w_mul_a;
    logic [63:0] w_mul_b;
    logic [63:0] w_prod;
    logic        w_mul_done;
    logic        w_div_start;
    logic [63:0] w_div_n;
    logic [63:0] w_div_d;
    logic [63:0] w_quo;
    logic        w_div_done;

    logic [63:0] w_t1, w_t2, w_t3;
    logic [63:0] w_p1, w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;
    logic [63:0] w_h1, w_h2, w_h3, w_h4, w_h5, w_h6;

    assign w_t1 = {48'd0, r_c_temp[15:0]};
    assign w_t2 = {{48{r_c_temp[31]}}, r_c_temp[31:16]};
    assign w_t3 = {{48{r_c_temp[47]}}, r_c_temp[47:32]};
    assign w_p1 = {48'd0, r_c_plo[15:0]};
    assign w_p2 = {{48{r_c_plo[31]}}, r_c_plo[31:16]};
    assign w_p3 = {{48{r_c_plo[47]}}, r_c_plo[47:32]};
    assign w_p4 = {{48{r_c_plo[63]}}, r_c_plo[63:48]};
    assign w_p5 = {{48{r_c_phi[15]}}, r_c_phi[15:0]};
    assign w_p6 = {{48{r_c_phi[31]}}, r_c_phi[31:16]};
    assign w_p7 = {{48{r_c_phi[47]}}, r_c_phi[47:32]};
    assign w_p8 = {{48{r_c_phi[63]}}, r_c_phi[63:48]};
    assign w_p9 = {{48{r_c_p9[15]}}, r_c_p9};
    assign w_h1 = {56'd0, r_c_ha[7:0]};
    assign w_h2 = {{48{r_c_ha[23]}}, r_c_ha[23:8]};
    assign w_h3 = {56'd0, r_c_ha[31:24]};
    assign w_h6 = {{56{r_c_ha[39]}}, r_c_ha[39:32]};
    assign w_h4 = {{48{r_c_hb[15]}}, r_c_hb[15:0]};
    assign w_h5 = {{48{r_c_hb[31]}}, r_c_hb[31:16]};

    esc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_prod  (w_prod),
        .o_done  (w_mul_done)
    );

    esc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_n),
        .i_den   (w_div_d),
        .o_quo   (w_quo),
        .o_done  (w_div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_temp <= '0;
            r_c_plo  <= '0;
            r_c_phi  <= '0;
            r_c_p9   <= '0;
            r_c_ha   <= '0;
            r_c_hb   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TEMP:     r_c_temp <= i_cfg_data[47:0];
                CFG_PRESS_LO: r_c_plo  <= i_cfg_data;
                CFG_PRESS_HI: r_c_phi  <= i_cfg_data;
                CFG_PRESS_P9: r_c_p9   <= i_cfg_data[15:0];
                CFG_HUM_A:    r_c_ha   <= i_cfg_data[39:0];
                CFG_HUM_B:    r_c_hb   <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        logic [63:0] v_a;
        logic [63:0] v_b;
        logic [31:0] v_w32;
        logic [63:0] v_cl;
        logic [7:0]  v_cnt1;
        logic [20:0] v_avg;

        n_state     = r_state;
        n_step      = r_step;
        n_in        = r_in;
        n_ra        = r_ra;
        n_rb        = r_rb;
        n_rc        = r_rc;
        n_rd        = r_rd;
        n_neg       = r_neg;
        n_fine      = r_fine;
        n_sum       = r_sum;
        n_cnt       = r_cnt;
        n_zflag     = r_zflag;
        n_temp      = r_temp;
        n_hum       = r_hum;
        n_out       = r_out;
        n_ovalid    = r_ovalid;
        w_mul_start = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_div_start = 1'b0;
        w_div_n     = '0;
        w_div_d     = '0;
        v_a         = '0;
        v_b         = '0;
        v_w32       = '0;
        v_cl        = '0;
        v_cnt1      = '0;
        v_avg       = '0;

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_in    = i_in.data;
                    n_state = S_RUN;
                    if (r_cnt == 8'd0) begin
                        n_sum   = '0;
                        n_zflag = 1'b0;
                        n_step  = ST_T0;
                    end else begin
                        n_step = r_zflag ? ST_END : ST_P0;
                    end
                end
            end
            S_WAIT: begin
                if (w_mul_done || w_div_done) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                n_step = r_step + 5'd1;
                case (r_step)
                    ST_T0: begin
                        w_mul_start = 1'b1;
                        w_mul_a = {47'd0, r_in.raw_temp[19:3]} - {w_t1[62:0], 1'b0};
                        w_mul_b = w_t2;
                    end
                    ST_T1: begin
                        n_ra = sra64(w_prod, 11);
                        v_a = {48'd0, r_in.raw_temp[19:4]} - w_t1;
                        w_mul_start = 1'b1;
                        w_mul_a = v_a;
                        w_mul_b = v_a;
                    end
                    ST_T2: begin
                        w_mul_start = 1'b1;
                        w_mul_a = sra64(w_prod, 12);
                        w_mul_b = w_t3;
                    end
                    ST_T3: begin
                        v_a = r_ra + sra64(w_prod, 14);
                        n_ra = v_a;
                        n_fine = v_a[31:0];
                    end
                    ST_T4: begin
                        v_a = {r_ra[61:0], 2'b00} + r_ra + 64'd128;
                        n_temp = v_a[23:8];
                    end
                    ST_H0: begin
                        v_w32 = r_fine - 32'd76800;
                        v_a = {{32{v_w32[31]}}, v_w32};
                        n_ra = v_a;
                        n_rb = sx32(({48'd0, r_in.raw_hum} << 14) - (w_h4 << 20)
                                    + 64'd16384);
                        w_mul_start = 1'b1;
                        w_mul_a = w_h5;
                        w_mul_b = v_a;
                    end
                    ST_H1: begin
                        n_rb = sra64(sx32(r_rb - w_prod), 15);
                        w_mul_start = 1'b1;
                        w_mul_a = r_ra;
                        w_mul_b = w_h6;
                    end
                    ST_H2: begin
                        n_rc = sra64(sx32(w_prod), 10);
                        w_mul_start = 1'b1;
                        w_mul_a = r_ra;
                        w_mul_b = w_h3;
                    end
                    ST_H3: begin
                        w_mul_start = 1'b1;
                        w_mul_a = r_rc;
                        w_mul_b = sx32(sra64(sx32(w_prod), 11) + 64'd32768);
                    end
                    ST_H4: begin
                        w_mul_start = 1'b1;
                        w_mul_a = sx32(sra64(sx32(w_prod), 10) + 64'd2097152);
                        w_mul_b = w_h2;
                    end
                    ST_H5: begin
                        w_mul_start = 1'b1;
                        w_mul_a = r_rb;
                        w_mul_b = sra64(sx32(w_prod + 64'd8192), 14);
                    end
                    ST_H6: begin
                        n_ra = sx32(w_prod);
                        v_a = sra64(sx32(w_prod), 15);
                        w_mul_start = 1'b1;
                        w_mul_a = v_a;
                        w_mul_b = v_a;
                    end
                    ST_H7: begin
                        w_mul_start = 1'b1;
                        w_mul_a = sra64(sx32(w_prod), 7);
                        w_mul_b = w_h1;
                    end
                    ST_H8: begin
                        v_a = sx32(r_ra - sra64(sx32(w_prod), 4));
                        if (v_a[31]) begin
                            v_cl = '0;
                        end else if (v_a[31:0] > 32'd419430400) begin
                            v_cl = 64'd419430400;
                        end else begin
                            v_cl = {32'd0, v_a[31:0]};
                        end
                        w_div_start = 1'b1;
                        w_div_n = v_cl >> 12;
                        w_div_d = 64'd1020;
                    end
                    ST_H9: begin
                        n_hum = w_quo[6:0];
                    end
                    ST_P0: begin
                        v_a = {{32{r_fine[31]}}, r_fine} - 64'd128000;
                        n_rd = v_a;
                        w_mul_start = 1'b1;
                        w_mul_a = v_a;
                        w_mul_b = v_a;
                    end
                    ST_P1: begin
                        n_ra = w_prod;
                        w_mul_start = 1'b1;
                        w_mul_a = w_prod;
                        w_mul_b = w_p6;
                    end
                    ST_P2: begin
                        n_rb = w_prod;
                        w_mul_start = 1'b1;
                        w_mul_a = r_rd;
                        w_mul_b = w_p5;
                    end
                    ST_P3: begin
                        n_rb = r_rb + (w_prod << 17);
                        w_mul_start = 1'b1;
                        w_mul_a = r_ra;
                        w_mul_b = w_p3;
                    end
                    ST_P4: begin
                        n_rb = r_rb + (w_p4 << 35);
                        n_rc = sra64(w_prod, 8);
                        w_mul_start = 1'b1;
                        w_mul_a = r_rd;
                        w_mul_b = w_p2;
                    end
                    ST_P5: begin
                        n_rc = r_rc + (w_prod << 12);
                    end
                    ST_P6: begin
                        w_mul_start = 1'b1;
                        w_mul_a = 64'h0000_8000_0000_0000 + r_rc;
                        w_mul_b = w_p1;
                    end
                    ST_P7: begin
                        v_a = sra64(w_prod, 33);
                        if (v_a == 64'd0) begin
                            n_zflag = 1'b1;
                            n_step = ST_END;
                        end else begin
                            n_rc = v_a;
                            v_b = 64'd1048576 - {44'd0, r_in.raw_press};
                            w_mul_start = 1'b1;
                            w_mul_a = (v_b << 31) - r_rb;
                            w_mul_b = 64'd3125;
                        end
                    end
                    ST_P8: begin
                        n_neg = w_prod[63] ^ r_rc[63];
                        w_div_start = 1'b1;
                        w_div_n = w_prod[63] ? (64'd0 - w_prod) : w_prod;
                        w_div_d = r_rc[63] ? (64'd0 - r_rc) : r_rc;
                    end
                    ST_P9: begin
                        v_a = r_neg ? (64'd0 - w_quo) : w_quo;
                        n_ra = v_a;
                        w_mul_start = 1'b1;
                        w_mul_a = w_p9;
                        w_mul_b = sra64(v_a, 13);
                    end
                    ST_P10: begin
                        w_mul_start = 1'b1;
                        w_mul_a = w_prod;
                        w_mul_b = sra64(r_ra, 13);
                    end
                    ST_P11: begin
                        n_rb = sra64(w_prod, 25);
                        w_mul_start = 1'b1;
                        w_mul_a = w_p8;
                        w_mul_b = r_ra;
                    end
                    ST_P12: begin
                        n_rd = r_ra + r_rb + sra64(w_prod, 19);
                    end
                    ST_P13: begin
                        n_rd = sra64(r_rd, 8) + (w_p7 << 4);
                    end
                    ST_P14: begin
                        if (r_rd[63]) begin
                            v_cl = '0;
                        end else if (r_rd[63:32] != 32'd0) begin
                            v_cl = 64'h0000_0000_FFFF_FFFF;
                        end else begin
                            v_cl = r_rd;
                        end
                        n_sum = r_sum + v_cl[39:0];
                        n_step = ST_END;
                    end
                    ST_END: begin
                        v_cnt1 = r_cnt + 8'd1;
                        if (v_cnt1 < 8'(MEANS)) begin
                            n_cnt = v_cnt1;
                            n_state = S_IDLE;
                        end else begin
                            w_div_start = 1'b1;
                            w_div_n = {24'd0, r_sum};
                            w_div_d = 64'(AVG_DIV);
                        end
                    end
                    ST_AVG: begin
                        n_step = ST_AVG;
                        if (!r_ovalid || o_out.ready) begin
                            if (r_zflag) begin
                                v_avg = '0;
                            end else if (w_quo > 64'd2097151) begin
                                v_avg = 21'd2097151;
                            end else begin
                                v_avg = w_quo[20:0];
                            end
                            n_out.temp_centi = r_temp;
                            n_out.press_deci_pa = v_avg;
                            n_out.hum_percent = r_hum;
                            n_out.press_zero_div = r_zflag;
                            n_ovalid = 1'b1;
                            n_cnt = '0;
                            n_sum = '0;
                            n_zflag = 1'b0;
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
                if (w_mul_start || w_div_start) begin
                    n_state = S_WAIT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= ST_T0;
            r_fine   <= '0;
            r_sum    <= '0;
            r_cnt    <= '0;
            r_zflag  <= 1'b0;
            r_temp   <= '0;
            r_hum    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_fine   <= n_fine;
            r_sum    <= n_sum;
            r_cnt    <= n_cnt;
            r_zflag  <= n_zflag;
            r_temp   <= n_temp;
            r_hum    <= n_hum;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_ra  <= n_ra;
        r_rb  <= n_rb;
        r_rc  <= n_rc;
        r_rd  <= n_rd;
        r_neg <= n_neg;
        r_out <= n_out;
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;

endmodule

// ===== rtl/esc_checker.sv =====
`timescale 1ns / 1ps

module esc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input esc_pkg::t_out_word i_out_data
);
    import esc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word dropped while stalled");

    a_zero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.press_zero_div |-> i_out_data.press_deci_pa == 21'd0)
        else $error("pressure not zero with zero divisor flag");

    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data.hum_percent <= 7'd100)
        else $error("humidity above one hundred percent");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind env_sensor_compensation_core esc_checker u_esc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
